// ===== sv/sclfu_pkg.sv =====
// Shared types and constants for the sector cache LFU tag engine.
// No dependencies; used by sclfu_cell and sector_cache_lfu_tags_top.
package sclfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W      = 32;
  localparam int AGE_W      = 16;
  localparam int CNT_W      = 32;
  localparam int SLOT_W     = 4;
  localparam logic [AGE_W-1:0] INSERT_AGE = AGE_W'(10);
  localparam logic [AGE_W-1:0] AGE_MAX    = '1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPLY
  } state_t;

  // Search token walking down the cell chain.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [AGE_W:0]   best_age;  // one bit wider so any stored age beats the seed
    logic [IDX_W-1:0] best_idx;
  } tok_t;

  // Table update broadcast to all cells.
  typedef struct packed {
    logic             en;
    cmd_t             kind;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } op_t;

endpackage

// ===== sv/sclfu_cell.sv =====
// One table entry (tag, age, valid) plus one stage of the search chain.
// Depends on sclfu_pkg.
module sclfu_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sclfu_pkg::IDX_W-1:0] my_idx,
  input  logic [sclfu_pkg::TAG_W-1:0] search_tag,
  input  sclfu_pkg::tok_t           tok_in,
  output sclfu_pkg::tok_t           tok_out,
  input  sclfu_pkg::op_t            op
);

  logic [sclfu_pkg::TAG_W-1:0] tag;
  logic [sclfu_pkg::AGE_W-1:0] age;
  logic                        valid;
  sclfu_pkg::tok_t             tok_next;

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found && valid && (tag == search_tag)) begin
      tok_next.found = 1'b1;
      tok_next.idx   = my_idx;
    end
    if ({1'b0, age} < tok_in.best_age) begin
      tok_next.best_age = {1'b0, age};
      tok_next.best_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (op.en) begin
      if (op.kind == sclfu_pkg::CMD_CLEAR) begin
        valid <= 1'b0;
        age   <= '0;
      end else if (op.idx == my_idx) begin
        unique case (op.kind)
          sclfu_pkg::CMD_LOOKUP: begin
            if (age != sclfu_pkg::AGE_MAX) age <= age + 1'b1;
          end
          sclfu_pkg::CMD_INSERT: begin
            valid <= 1'b1;
            age   <= sclfu_pkg::INSERT_AGE;
          end
          sclfu_pkg::CMD_INVAL: begin
            valid <= 1'b0;
            age   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // tag only matters while valid
  always_ff @(posedge clk) begin
    if (op.en && (op.kind == sclfu_pkg::CMD_INSERT) && (op.idx == my_idx)) begin
      tag <= op.tag;
    end
  end

endmodule

// ===== sv/sector_cache_lfu_tags_top.sv =====
// Sector cache LFU tag engine: top level, command FSM, counters, output register.
// Takes one command at a time: a new command is accepted only in idle, once the search token,
// stepping one cell per cycle, has left the chain and its result has been applied.
// The output register lets a new command enter while a result waits.
// Reset (rst, synchronous, active high): all entries invalid, ages and counters zero.
// Depends on sclfu_pkg and sclfu_cell.
module sector_cache_lfu_tags_top (
  input  logic        clk,
  input  logic        rst,
  // command word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sector_num
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [3:0] slot, [35:4] hit_total, [67:36] miss_total, rest 0
  output logic        m_tuser    // [0] hit
);

  localparam int N = sclfu_pkg::ENTRIES;

  sclfu_pkg::state_t state, state_next;

  // held command
  sclfu_pkg::cmd_t             cmd;
  logic [sclfu_pkg::TAG_W-1:0] sector;
  logic                        inject;

  // token chain: tok[0] feeds cell 0, tok[N] leaves the last cell
  sclfu_pkg::tok_t tok [N+1];
  sclfu_pkg::tok_t tail;
  sclfu_pkg::op_t  op;

  logic [sclfu_pkg::CNT_W-1:0] hit_cnt, miss_cnt;
  logic [sclfu_pkg::CNT_W-1:0] hit_cnt_next, miss_cnt_next;

  logic                         res_hit;
  logic [sclfu_pkg::IDX_W-1:0]  res_idx;
  logic [sclfu_pkg::IDX_W+3:0]  res_idx_wide;
  logic                         accept;
  logic                         load_out;

  assign s_tready = (state == sclfu_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // seed token: nothing found yet, best age above any stored age
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = inject;
    tok[0].best_age = '1;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    sclfu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .my_idx     (sclfu_pkg::IDX_W'(i)),
      .search_tag (sector),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .op         (op)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sclfu_pkg::ST_IDLE;
      inject <= 1'b0;
    end else begin
      state  <= state_next;
      inject <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= sclfu_pkg::cmd_t'(s_tuser);
      sector <= s_tdata;
    end
    if (tok[N].vld) tail <= tok[N];
  end

  // next state, table update and result fields
  always_comb begin
    state_next    = state;
    load_out      = 1'b0;
    op            = '0;
    op.kind       = cmd;
    op.tag        = sector;
    res_hit       = 1'b0;
    res_idx       = '0;
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    unique case (state)
      sclfu_pkg::ST_IDLE: begin
        if (accept) state_next = sclfu_pkg::ST_WALK;
      end
      sclfu_pkg::ST_WALK: begin
        if (tok[N].vld) state_next = sclfu_pkg::ST_APPLY;
      end
      sclfu_pkg::ST_APPLY: begin
        // wait for a free output register before touching the table
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = sclfu_pkg::ST_IDLE;
          unique case (cmd)
            sclfu_pkg::CMD_LOOKUP: begin
              res_hit = tail.found;
              res_idx = tail.found ? tail.idx : '0;
              op.en   = tail.found;
              op.idx  = tail.idx;
              if (tail.found) hit_cnt_next = hit_cnt + 1'b1;
              else            miss_cnt_next = miss_cnt + 1'b1;
            end
            sclfu_pkg::CMD_INSERT: begin
              res_idx = tail.best_idx;
              op.en   = 1'b1;
              op.idx  = tail.best_idx;
            end
            sclfu_pkg::CMD_INVAL: begin
              res_hit = tail.found;
              res_idx = tail.found ? tail.idx : '0;
              op.en   = tail.found;
              op.idx  = tail.idx;
            end
            sclfu_pkg::CMD_CLEAR: begin
              op.en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: state_next = sclfu_pkg::ST_IDLE;
    endcase
  end

  // slot is the low four bits of the index
  assign res_idx_wide = {4'b0000, res_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_hit;
      m_tdata <= {4'b0000, miss_cnt_next, hit_cnt_next, res_idx_wide[3:0]};
    end
  end

  // ---------------- assertions ----------------
  logic [N:0] tok_vld_vec;
  always_comb begin
    for (int k = 0; k <= N; k++) tok_vld_vec[k] = tok[k].vld;
  end

  // only one command is ever in flight in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one search token in the chain");

  // no command is taken while a token is still walking
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (tok_vld_vec == '0))
    else $error("command accepted with a search in flight");

  // a new result only comes out of the apply step
  a_out_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == sclfu_pkg::ST_APPLY))
    else $error("result raised outside the apply step");

  // counters move only when a lookup is applied
  a_cnt_on_lookup: assert property (@(posedge clk) disable iff (rst)
    !(load_out && cmd == sclfu_pkg::CMD_LOOKUP) |=> $stable(hit_cnt) && $stable(miss_cnt))
    else $error("hit or miss counter changed without a lookup");

endmodule

// ===== bench/sector_cache_lfu_tags_top_tb.sv =====
// Self-checking bench for the sector cache LFU tag engine (sector_cache_lfu_tags_top).
// Holds a scoreboard class that predicts every result word; depends on sclfu_pkg and the top.
`timescale 1ns / 1ps

import sclfu_pkg::*;

// Predicts the tag table and counters, and holds the expected result words in order.
class sector_tag_scoreboard;
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } cache_result_t;

  logic [TAG_W-1:0] tag_mem[ENTRIES];
  logic [AGE_W-1:0] age_mem[ENTRIES];
  bit               valid_mem[ENTRIES];
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  cache_result_t    expected_q[$];
  int unsigned      checked;

  function new();
    clear_table();
    hit_cnt  = '0;
    miss_cnt = '0;
    checked  = 0;
  endfunction

  function void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tag_mem[i]   = '0;
      age_mem[i]   = '0;
      valid_mem[i] = 1'b0;
    end
  endfunction

  // lowest valid entry holding the tag, -1 if none
  function int find_tag(logic [TAG_W-1:0] t);
    for (int i = 0; i < ENTRIES; i++)
      if (valid_mem[i] && tag_mem[i] == t) return i;
    return -1;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Called once per accepted command word.
  function void note_command(cmd_t c, logic [TAG_W-1:0] sec);
    cache_result_t r;
    int idx;
    int best;
    r   = '0;
    idx = find_tag(sec);
    case (c)
      CMD_LOOKUP: begin
        if (idx >= 0) begin
          if (age_mem[idx] != AGE_MAX) age_mem[idx] = age_mem[idx] + 1'b1;
          hit_cnt = hit_cnt + 1'b1;
          r.hit   = 1'b1;
          r.slot  = SLOT_W'(idx);
        end else begin
          miss_cnt = miss_cnt + 1'b1;
        end
      end
      CMD_INSERT: begin
        // first entry of least age; empty entries sit at age 0
        best = 0;
        for (int i = 1; i < ENTRIES; i++)
          if (age_mem[i] < age_mem[best]) best = i;
        tag_mem[best]   = sec;
        age_mem[best]   = INSERT_AGE;
        valid_mem[best] = 1'b1;
        r.slot          = SLOT_W'(best);
      end
      CMD_INVAL: begin
        if (idx >= 0) begin
          tag_mem[idx]   = '0;
          age_mem[idx]   = '0;
          valid_mem[idx] = 1'b0;
          r.hit          = 1'b1;
          r.slot         = SLOT_W'(idx);
        end
      end
      default: clear_table();  // counters survive a clear
    endcase
    r.hit_total  = hit_cnt;
    r.miss_total = miss_cnt;
    expected_q.push_back(r);
  endfunction

  // Compares one result word with the oldest expectation; empty string on match.
  function string check_result(logic hit, logic [71:0] data);
    cache_result_t e;
    string msg;
    if (expected_q.size() == 0) return "result word with no command pending";
    e = expected_q.pop_front();
    checked++;
    msg = "";
    if (hit !== e.hit)
      msg = {msg, $sformatf(" hit %0b/%0b", hit, e.hit)};
    if (data[SLOT_W-1:0] !== e.slot)
      msg = {msg, $sformatf(" slot %0d/%0d", data[SLOT_W-1:0], e.slot)};
    if (data[SLOT_W +: CNT_W] !== e.hit_total)
      msg = {msg, $sformatf(" hit_total %0d/%0d", data[SLOT_W +: CNT_W], e.hit_total)};
    if (data[SLOT_W+CNT_W +: CNT_W] !== e.miss_total)
      msg = {msg, $sformatf(" miss_total %0d/%0d", data[SLOT_W+CNT_W +: CNT_W],
                            e.miss_total)};
    if (data[71:SLOT_W+2*CNT_W] !== '0)
      msg = {msg, $sformatf(" pad %h/0", data[71:SLOT_W+2*CNT_W])};
    if (msg != "") msg = $sformatf("result %0d (got/exp):%s", checked, msg);
    return msg;
  endfunction
endclass

module sector_cache_lfu_tags_top_tb;

  localparam int POOL_SIZE  = 24;    // recurring sectors; more than ENTRIES forces evictions
  localparam int RAND_ITEMS = 1100;
  localparam int SETTLE     = 2 * (ENTRIES + 3);
  localparam int MAX_PRINTS = 50;

  // all block inputs start at known values
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] sector_num
  logic [1:0]  s_tuser  = CMD_LOOKUP;  // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // [3:0] slot, [35:4] hit_total, [67:36] miss_total, rest 0
  logic        m_tuser;         // [0] hit

  sector_tag_scoreboard sb = new();

  int unsigned errors    = 0;
  bit          jitter_on = 1'b1;   // random idling on both sides
  logic [31:0] pool[POOL_SIZE];

  sector_cache_lfu_tags_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // One line per mismatch, capped so a broken block cannot flood the log.
  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
  endtask

  // Present a command word and hold it until the block takes it.
  // Handshake is sampled right at the edge, before the block's own updates land.
  task automatic send_word(cmd_t c, logic [31:0] sec);
    s_tvalid <= 1'b1;
    s_tdata  <= sec;
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_command(c, sec);
  endtask

  // Occasional gap after a word; lengths vary so gaps hit every phase of the walk.
  task automatic idle_gap();
    if (jitter_on && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2 * (ENTRIES + 3))) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result word is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver: check each accepted result word, then pick next cycle's ready.
  always @(posedge clk) begin : rx_side
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      msg = sb.check_result(m_tuser, m_tdata);
      if (msg != "") report(msg);
    end
    m_tready <= !(jitter_on && $urandom_range(99) < 7);
  end

  // Stimulus
  initial begin : stim
    cmd_t        c;
    logic [31:0] sec;
    int          r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extreme tags, duplicates, invalidate, clear.
    send_word(CMD_LOOKUP, 32'h0000_0000); idle_gap();  // miss on empty table
    send_word(CMD_INVAL,  32'h0000_0000); idle_gap();  // invalidate miss
    send_word(CMD_CLEAR,  32'hFFFF_FFFF); idle_gap();  // clear of an empty table
    send_word(CMD_INSERT, 32'h0000_0000); idle_gap();  // slot 0
    send_word(CMD_INSERT, 32'hFFFF_FFFF); idle_gap();  // slot 1, empty filled first
    send_word(CMD_LOOKUP, 32'h0000_0000); idle_gap();
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF); idle_gap();
    send_word(CMD_INSERT, 32'h0000_0000); idle_gap();  // duplicate tag goes to slot 2
    send_word(CMD_LOOKUP, 32'h0000_0000); idle_gap();  // lowest duplicate wins
    send_word(CMD_INVAL,  32'h0000_0000); idle_gap();  // empties slot 0 only
    send_word(CMD_LOOKUP, 32'h0000_0000); idle_gap();  // now the copy in slot 2
    send_word(CMD_INSERT, 32'h8000_0000); idle_gap();  // reuses freed slot 0
    send_word(CMD_INSERT, 32'h5555_5555); idle_gap();
    send_word(CMD_INSERT, 32'hAAAA_AAAA); idle_gap();
    send_word(CMD_INVAL,  32'hAAAA_AAAA); idle_gap();
    send_word(CMD_INVAL,  32'hAAAA_AAAA); idle_gap();  // second time misses
    send_word(CMD_LOOKUP, 32'h0000_0001); idle_gap();
    send_word(CMD_LOOKUP, 32'h5555_5555); idle_gap();
    send_word(CMD_CLEAR,  32'h1234_5678); idle_gap();  // counters must survive
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF); idle_gap();  // miss after clear
    send_word(CMD_INSERT, 32'h7FFF_FFFF); idle_gap();  // slot 0 again, all ages tied
    send_word(CMD_INSERT, 32'hFFFF_FFFE); idle_gap();
    send_word(CMD_LOOKUP, 32'h7FFF_FFFF); idle_gap();
    drain();

    // Sector pool: a few extremes, the rest random
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;

    // Random: mostly lookups on recurring sectors, enough inserts to fill the
    // table and force LFU evictions, rare clears.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400) jitter_on <= 1'b0;   // long stretch with no idling
      if (n == 700) jitter_on <= 1'b1;
      r = $urandom_range(999);
      if (r < 575)      c = CMD_LOOKUP;
      else if (r < 875) c = CMD_INSERT;
      else if (r < 995) c = CMD_INVAL;
      else              c = CMD_CLEAR;
      if ($urandom_range(99) < 75) begin
        sec = pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        sec = $urandom;
        // fresh inserted sectors join the pool so later lookups can hit them
        if (c == CMD_INSERT) pool[$urandom_range(POOL_SIZE - 1)] = sec;
      end
      send_word(c, sec);
      if (n == 300 || n == 800) drain();
      else idle_gap();
    end
    s_tvalid <= 1'b0;

    // wait out every result word, then a little extra for stray output
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sclfu_pkg.sv
sv/sclfu_cell.sv
sv/sector_cache_lfu_tags_top.sv
bench/sector_cache_lfu_tags_top_tb.sv
